// File: hdl/fraction_sum_reducer_unit_macros.svh
// Assertion macros for the checker file of the fraction sum reducer.
`ifndef FRACTION_SUM_REDUCER_UNIT_MACROS_SVH
`define FRACTION_SUM_REDUCER_UNIT_MACROS_SVH

// Checked only outside reset.
`define FSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/fsr_pkg.sv
// Package: widths, state types and shared constants of the fraction sum reducer.
package fsr_pkg;

   localparam int IN_WIDTH    = 16;
   localparam int ACC_WIDTH   = 32;
   localparam int PROD_WIDTH  = ACC_WIDTH + IN_WIDTH;
   localparam int WIDE_WIDTH  = PROD_WIDTH + 1;
   localparam int SHIFT_WIDTH = $clog2(WIDE_WIDTH);

   typedef logic [WIDE_WIDTH-1:0]  wide_type;
   typedef logic [SHIFT_WIDTH-1:0] shift_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_REDUCE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_SAT,
      ST_EMIT
   } fsr_state_type;

   typedef enum logic [1:0] {
      GCD_IDLE,
      GCD_TWOS,
      GCD_LOOP,
      GCD_DONE
   } gcd_state_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

// File: hdl/fraction_sum_reducer_unit.sv
// Top level: fraction accumulator with gcd reduction, sequenced over shared units.
//
// Usage
//  - Request channel (req_*): one fraction per request, numerator, denominator
//    (zero is taken as one) and a last-of-set flag. Accepted when req_valid is
//    high and req_stall low; req_stall is high while a request is in work
//    and during reset.
//  - Response channel (rsp_*): one response per set, on the request that has
//    req_last_item set: reduced sum and a sticky overflow flag for the set.
//  - Each request runs its multiplies (MUL_A, MUL_B, MUL_C) on one 32x16
//    multiplier, then a binary gcd (one subtract or shift per cycle) and two
//    restoring divisions on one divider. A zero sum skips gcd and divisions.
//  - The response sits in an output register; a new request is taken while
//    it waits. If another response is ready while rsp_stall holds the old
//    one, the sequencer waits in its emit step until the register frees.
//  - Reset (synchronous, active high) clears the sum to 0/1, the overflow
//    flag and all valid flags.
//  - Reduced values above 32 bits saturate to all ones and set overflow.
module fraction_sum_reducer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fsr_pkg::IN_WIDTH-1:0]    req_frac_num,
   input  logic [fsr_pkg::IN_WIDTH-1:0]    req_frac_den,
   input  logic                            req_last_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fsr_pkg::ACC_WIDTH-1:0]   rsp_sum_num,
   output logic [fsr_pkg::ACC_WIDTH-1:0]   rsp_sum_den,
   output logic                            rsp_overflow
);

   localparam int IW = fsr_pkg::IN_WIDTH;
   localparam int AW = fsr_pkg::ACC_WIDTH;
   localparam int PW = fsr_pkg::PROD_WIDTH;
   localparam int WW = fsr_pkg::WIDE_WIDTH;

   fsr_pkg::fsr_state_type state_ff, state_in;

   // request holding registers
   logic [IW-1:0] n_ff, n_in, d_ff, d_in;
   logic          last_ff, last_in;

   // running sum
   logic [AW-1:0] acc_num_ff, acc_num_in, acc_den_ff, acc_den_in;
   logic          acc_ovf_ff, acc_ovf_in;

   // work registers
   logic [PW-1:0]     prod_ff, prod_in;
   fsr_pkg::wide_type num_ff, num_in, g_ff, g_in, qnum_ff, qnum_in, qden_ff, qden_in;

   // response register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   // shared multiplier
   logic [AW-1:0] mul_a;
   logic [IW-1:0] mul_b;
   logic [PW-1:0] mul_p;

   // shared units
   logic              gcd_start, gcd_done;
   fsr_pkg::wide_type gcd_g;
   logic              div_start, div_done;
   fsr_pkg::wide_type div_dividend, div_divisor, div_q;

   logic num_hi, den_hi, rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign num_hi   = |qnum_ff[WW-1:AW];
   assign den_hi   = |qden_ff[WW-1:AW];
   assign mul_p    = PW'(mul_a) * PW'(mul_b);

   fsr_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start),
      .a_val   (num_ff),
      .b_val   (WW'(prod_ff)),
      .done    (gcd_done),
      .gcd_val (gcd_g)
   );

   fsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsr_pkg::ST_IDLE:    if (req_valid) state_in = fsr_pkg::ST_MUL_A;
         fsr_pkg::ST_MUL_A:   state_in = fsr_pkg::ST_MUL_B;
         fsr_pkg::ST_MUL_B:   state_in = fsr_pkg::ST_MUL_C;
         fsr_pkg::ST_MUL_C:   state_in = fsr_pkg::ST_REDUCE;
         fsr_pkg::ST_REDUCE: begin
            state_in = (num_ff == '0) ? fsr_pkg::ST_SAT : fsr_pkg::ST_GCD;
         end
         fsr_pkg::ST_GCD:     if (gcd_done) state_in = fsr_pkg::ST_DIV_NUM;
         fsr_pkg::ST_DIV_NUM: if (div_done) state_in = fsr_pkg::ST_DIV_DEN;
         fsr_pkg::ST_DIV_DEN: if (div_done) state_in = fsr_pkg::ST_SAT;
         fsr_pkg::ST_SAT: begin
            state_in = last_ff ? fsr_pkg::ST_EMIT : fsr_pkg::ST_IDLE;
         end
         fsr_pkg::ST_EMIT:    if (rsp_free) state_in = fsr_pkg::ST_IDLE;
         default:             state_in = fsr_pkg::ST_IDLE;
      endcase
   end

   // datapath and unit control
   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      last_in      = last_ff;
      acc_num_in   = acc_num_ff;
      acc_den_in   = acc_den_ff;
      acc_ovf_in   = acc_ovf_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      g_in         = g_ff;
      qnum_in      = qnum_ff;
      qden_in      = qden_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mul_a        = acc_den_ff;
      mul_b        = d_ff;
      gcd_start    = 1'b0;
      div_start    = 1'b0;
      div_dividend = num_ff;
      div_divisor  = g_ff;
      unique case (state_ff)
         fsr_pkg::ST_IDLE: begin
            if (req_valid) begin
               n_in    = req_frac_num;
               d_in    = (req_frac_den == '0) ? IW'(1) : req_frac_den;
               last_in = req_last_item;
            end
         end
         fsr_pkg::ST_MUL_A: begin
            mul_a   = acc_num_ff;
            mul_b   = d_ff;
            prod_in = mul_p;
         end
         fsr_pkg::ST_MUL_B: begin
            mul_a   = acc_den_ff;
            mul_b   = n_ff;
            num_in  = WW'(prod_ff);
            prod_in = mul_p;
         end
         fsr_pkg::ST_MUL_C: begin
            // cross sum; den = acc_den * d lands in prod_ff
            mul_a   = acc_den_ff;
            mul_b   = d_ff;
            num_in  = num_ff + WW'(prod_ff);
            prod_in = mul_p;
         end
         fsr_pkg::ST_REDUCE: begin
            if (num_ff == '0) begin
               // zero sum: no reduction of the denominator
               qnum_in = '0;
               qden_in = WW'(prod_ff);
            end else begin
               gcd_start = 1'b1;
            end
         end
         fsr_pkg::ST_GCD: begin
            div_dividend = num_ff;
            div_divisor  = gcd_g;
            if (gcd_done) begin
               g_in      = gcd_g;
               div_start = 1'b1;
            end
         end
         fsr_pkg::ST_DIV_NUM: begin
            div_dividend = WW'(prod_ff);
            div_divisor  = g_ff;
            if (div_done) begin
               qnum_in   = div_q;
               div_start = 1'b1;
            end
         end
         fsr_pkg::ST_DIV_DEN: begin
            if (div_done) qden_in = div_q;
         end
         fsr_pkg::ST_SAT: begin
            acc_num_in = num_hi ? '1 : qnum_ff[AW-1:0];
            acc_den_in = den_hi ? '1 : qden_ff[AW-1:0];
            acc_ovf_in = acc_ovf_ff | num_hi | den_hi;
         end
         fsr_pkg::ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = acc_num_ff;
               rsp_den_in   = acc_den_ff;
               rsp_ovf_in   = acc_ovf_ff;
               acc_num_in   = '0;
               acc_den_in   = AW'(1);
               acc_ovf_in   = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsr_pkg::ST_IDLE;
         acc_num_ff   <= '0;
         acc_den_ff   <= AW'(1);
         acc_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_num_ff   <= acc_num_in;
         acc_den_ff   <= acc_den_in;
         acc_ovf_ff   <= acc_ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff       <= n_in;
      d_ff       <= d_in;
      last_ff    <= last_in;
      prod_ff    <= prod_in;
      num_ff     <= num_in;
      g_ff       <= g_in;
      qnum_ff    <= qnum_in;
      qden_ff    <= qden_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   // no request is taken while reset is applied
   assign req_stall    = reset || (state_ff != fsr_pkg::ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sum_num  = rsp_num_ff;
   assign rsp_sum_den  = rsp_den_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

// File: hdl/fsr_gcd.sv
// Iterative binary gcd: one compare/subtract or one shift per cycle.
module fsr_gcd (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fsr_pkg::wide_type a_val,
   input  fsr_pkg::wide_type b_val,
   output logic              done,
   output fsr_pkg::wide_type gcd_val
);

   fsr_pkg::gcd_state_type state_ff, state_in;
   fsr_pkg::wide_type      a_ff, a_in, b_ff, b_in;
   fsr_pkg::shift_type     k_ff, k_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsr_pkg::GCD_IDLE: begin
            if (start) state_in = fsr_pkg::GCD_TWOS;
         end
         fsr_pkg::GCD_TWOS: begin
            if (a_ff[0] || b_ff[0]) state_in = fsr_pkg::GCD_LOOP;
         end
         fsr_pkg::GCD_LOOP: begin
            if (a_ff == '0) state_in = fsr_pkg::GCD_DONE;
         end
         fsr_pkg::GCD_DONE: state_in = fsr_pkg::GCD_IDLE;
         default: state_in = fsr_pkg::GCD_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      unique case (state_ff)
         fsr_pkg::GCD_IDLE: begin
            if (start) begin
               a_in = a_val;
               b_in = b_val;
               k_in = '0;
            end
         end
         fsr_pkg::GCD_TWOS: begin
            if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end
         end
         fsr_pkg::GCD_LOOP: begin
            if (a_ff != '0) begin
               if (!a_ff[0])          a_in = a_ff >> 1;
               else if (!b_ff[0])     b_in = b_ff >> 1;
               else if (a_ff >= b_ff) a_in = a_ff - b_ff;
               else                   b_in = b_ff - a_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsr_pkg::GCD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   assign done    = (state_ff == fsr_pkg::GCD_DONE);
   assign gcd_val = b_ff << k_ff;

endmodule

// File: hdl/fsr_div.sv
// Restoring divider: one quotient bit per cycle.
module fsr_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  fsr_pkg::wide_type dividend,
   input  fsr_pkg::wide_type divisor,
   output logic              done,
   output fsr_pkg::wide_type quotient
);

   localparam int W = fsr_pkg::WIDE_WIDTH;

   fsr_pkg::div_state_type state_ff, state_in;
   fsr_pkg::wide_type      q_ff, q_in, r_ff, r_in, dvs_ff, dvs_in;
   fsr_pkg::shift_type     count_ff, count_in;
   logic [W:0]             r_sh;
   logic [W:0]             r_diff;

   assign r_sh   = {r_ff, q_ff[W-1]};
   assign r_diff = r_sh - {1'b0, dvs_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fsr_pkg::DIV_IDLE: begin
            if (start) state_in = fsr_pkg::DIV_RUN;
         end
         fsr_pkg::DIV_RUN: begin
            if (count_ff == fsr_pkg::shift_type'(W - 1)) state_in = fsr_pkg::DIV_DONE;
         end
         // a new division may start in the done cycle
         fsr_pkg::DIV_DONE: state_in = start ? fsr_pkg::DIV_RUN : fsr_pkg::DIV_IDLE;
         default: state_in = fsr_pkg::DIV_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      q_in     = q_ff;
      r_in     = r_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      unique case (state_ff)
         fsr_pkg::DIV_IDLE: begin
            if (start) begin
               q_in     = dividend;
               r_in     = '0;
               dvs_in   = divisor;
               count_in = '0;
            end
         end
         fsr_pkg::DIV_RUN: begin
            count_in = count_ff + 1'b1;
            if (!r_diff[W]) begin
               r_in = r_diff[W-1:0];
               q_in = {q_ff[W-2:0], 1'b1};
            end else begin
               r_in = r_sh[W-1:0];
               q_in = {q_ff[W-2:0], 1'b0};
            end
         end
         fsr_pkg::DIV_DONE: begin
            if (start) begin
               q_in     = dividend;
               r_in     = '0;
               dvs_in   = divisor;
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsr_pkg::DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      q_ff     <= q_in;
      r_ff     <= r_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
   end

   assign done     = (state_ff == fsr_pkg::DIV_DONE);
   assign quotient = q_ff;

endmodule

// File: hdl/fsr_checker.sv
// Port-level checker for the fraction sum reducer, bound to the top level.
`include "fraction_sum_reducer_unit_macros.svh"

module fsr_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [fsr_pkg::ACC_WIDTH-1:0] rsp_sum_num,
   input logic [fsr_pkg::ACC_WIDTH-1:0] rsp_sum_den,
   input logic                          rsp_overflow
);

   `FSR_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid after reset")

   `FSR_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall, "no stall after accept")

   `FSR_ASSERT(a_den_nonzero, rsp_valid |-> (rsp_sum_den != '0), "zero denominator in response")

   `FSR_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sum_num) && $stable(rsp_sum_den) && $stable(rsp_overflow)), "stalled response changed")

endmodule

bind fraction_sum_reducer_unit fsr_checker u_fsr_checker (.*);

// File: tb/sv/tb_fraction_sum_reducer_unit.sv
// Testbench for the fraction sum reducer: directed and random fraction sets checked against a predictor.
module tb_fraction_sum_reducer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IN_WIDTH  = fsr_pkg::IN_WIDTH;
   localparam int ACC_WIDTH = fsr_pkg::ACC_WIDTH;

   localparam longint unsigned ACC_MAX = (64'd1 << ACC_WIDTH) - 1;
   localparam int DRAIN_CYCLES = 400;

   // Sum of one expected response.
   typedef struct {
      logic [ACC_WIDTH-1:0] sum_num;
      logic [ACC_WIDTH-1:0] sum_den;
      logic                 overflow;
   } sum_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [IN_WIDTH-1:0]  req_frac_num = '0;
   logic [IN_WIDTH-1:0]  req_frac_den = 16'd1;
   logic                 req_last_item = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ACC_WIDTH-1:0] rsp_sum_num;
   logic [ACC_WIDTH-1:0] rsp_sum_den;
   logic                 rsp_overflow;

   // Predictor state: running sum and sticky overflow of the open set.
   longint unsigned run_num = 64'd0;
   longint unsigned run_den = 64'd1;
   bit              run_ovf = 1'b0;

   sum_type expected_sums[$];
   int      error_count = 0;
   bit      quiet = 1'b0;   // no gaps and no stalls while set

   fraction_sum_reducer_unit dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if (quiet) return 0;
      if ($urandom_range(99) < 5) return $urandom_range(80, 20);
      if ($urandom_range(99) < 50) return 0;
      return $urandom_range(4, 1);
   endfunction

   function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
      longint unsigned t;
      if (a == 0 || b == 0) return 64'd1;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Fold one accepted request into the running sum; queue a response on last.
   task automatic predict_fraction(logic [IN_WIDTH-1:0] n, logic [IN_WIDTH-1:0] d_in,
                                   logic last);
      longint unsigned d, num, den, g;
      sum_type s;
      d = (d_in == '0) ? 64'd1 : 64'(d_in);   // zero denominator counts as one
      // Widths here keep every product well inside 64 bits.
      num = run_num * d + 64'(n) * run_den;
      den = run_den * d;
      g = gcd_of(num, den);              // zero sum leaves den unreduced
      num = num / g;
      den = den / g;
      if (num > ACC_MAX) begin
         num = ACC_MAX;
         run_ovf = 1'b1;
      end
      if (den > ACC_MAX) begin
         den = ACC_MAX;
         run_ovf = 1'b1;
      end
      run_num = num;
      run_den = den;
      if (last) begin
         s.sum_num = num[ACC_WIDTH-1:0];
         s.sum_den = den[ACC_WIDTH-1:0];
         s.overflow = run_ovf;
         expected_sums.push_back(s);
         run_num = 64'd0;
         run_den = 64'd1;
         run_ovf = 1'b0;
      end
   endtask

   // Drive one request at the falling edge and hold it until taken.
   task automatic send_fraction(logic [IN_WIDTH-1:0] n, logic [IN_WIDTH-1:0] d, logic last);
      int gap;
      @(negedge clock);
      req_frac_num  <= n;
      req_frac_den  <= d;
      req_last_item <= last;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_fraction(n, d, last);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Response side stall: bursts of random length.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         if (quiet) begin
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < 35);
            hold = ($urandom_range(99) < 5) ? $urandom_range(60, 15) : $urandom_range(3);
            repeat (hold + 1) @(negedge clock);
         end
      end
   end

   // Response checker: compare each accepted response with the oldest expected sum.
   always @(posedge clock) begin
      sum_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sums.size() == 0) begin
            $error("unexpected response num=%0d den=%0d", rsp_sum_num, rsp_sum_den);
            error_count++;
         end else begin
            e = expected_sums.pop_front();
            if (rsp_sum_num !== e.sum_num) begin
               $error("sum_num expected %0d actual %0d", e.sum_num, rsp_sum_num);
               error_count++;
            end
            if (rsp_sum_den !== e.sum_den) begin
               $error("sum_den expected %0d actual %0d", e.sum_den, rsp_sum_den);
               error_count++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow expected %0d actual %0d", e.overflow, rsp_overflow);
               error_count++;
            end
         end
      end
   end

   // Extremes, zero cases, reduction and saturation.
   task automatic test_directed();
      send_fraction(16'd0, 16'd1, 1'b1);          // 0/1
      send_fraction(16'd0, 16'd7, 1'b0);          // zero sum, den stays 7
      send_fraction(16'd0, 16'd9, 1'b1);
      send_fraction(16'd3, 16'd0, 1'b1);          // zero den taken as one
      send_fraction(16'hFFFF, 16'hFFFF, 1'b1);    // reduces to 1/1
      send_fraction(16'hFFFF, 16'd1, 1'b0);
      send_fraction(16'hFFFF, 16'd1, 1'b1);
      send_fraction(16'd1, 16'd2, 1'b0);
      send_fraction(16'd1, 16'd3, 1'b0);
      send_fraction(16'd1, 16'd6, 1'b1);          // sums to 1/1
      send_fraction(16'd1, 16'hFFFF, 1'b0);       // denominators grow past 32 bits
      send_fraction(16'd1, 16'hFFFE, 1'b0);
      send_fraction(16'd1, 16'hFFFD, 1'b1);
      send_fraction(16'h5555, 16'hAAAA, 1'b1);
      send_fraction(16'd0, 16'hFFFF, 1'b1);
   endtask

   // Random sets: mostly short, with mixed small and full-range values.
   task automatic test_random_sets(int count);
      int len, i;
      bit small_vals;
      logic [IN_WIDTH-1:0] n, d;
      while (count > 0) begin
         len = ($urandom_range(99) < 10) ? $urandom_range(12, 5) : $urandom_range(4, 1);
         small_vals = ($urandom_range(1) != 0);
         for (i = 0; i < len && count > 0; i++) begin
            if (small_vals) begin
               n = IN_WIDTH'($urandom_range(12));
               d = IN_WIDTH'($urandom_range(12, 1));
            end else begin
               n = IN_WIDTH'($urandom);
               d = IN_WIDTH'($urandom_range(16'hFFFF, 1));
            end
            send_fraction(n, d, (i == len - 1) || (count == 1));
            count--;
         end
      end
   endtask

   // Sender holds off until every expected sum has come back.
   task automatic test_drain_pause();
      send_fraction(16'd5, 16'd10, 1'b1);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      send_fraction(16'd2, 16'd4, 1'b0);
      send_fraction(16'd3, 16'd9, 1'b1);
   endtask

   // Back-to-back traffic with no idling on either side.
   task automatic test_no_idle();
      quiet = 1'b1;
      test_random_sets(60);
      quiet = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sets(300);
      test_drain_pause();
      test_no_idle();
      test_random_sets(320);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_sums.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end
endmodule
